>>> hw/rtl/task_dispatcher_with_timeout_requeue_assert.svh
// assertion macros used by the dispatcher sequencer
`ifndef TASK_DISPATCHER_WITH_TIMEOUT_REQUEUE_ASSERT_SVH
`define TASK_DISPATCHER_WITH_TIMEOUT_REQUEUE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TD_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("dispatcher check failed");

// next-cycle implication
`define TD_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("dispatcher check failed");

`endif

>>> hw/rtl/tdisp_pkg.sv
// ----------------------------------------------------------------------------
// tdisp_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package tdisp_pkg;

    localparam int MAX_TASKS = 1024;
    localparam int ID_W      = 10;
    localparam int LINK_W    = 11;
    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(MAX_TASKS);
    localparam logic [31:0] RESET_TIMEOUT = 32'd3600;

    localparam logic [0:0] CFG_TASK_COUNT   = 1'b0;
    localparam logic [0:0] CFG_TASK_TIMEOUT = 1'b1;

    localparam logic [1:0] ACT_REQUEST  = 2'd0;
    localparam logic [1:0] ACT_COMPLETE = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;

    localparam logic [1:0] LIST_PENDING = 2'd0;
    localparam logic [1:0] LIST_RUNNING = 2'd1;
    localparam logic [1:0] LIST_DONE    = 2'd2;

    typedef enum logic [2:0] {
        RES_GRANTED   = 3'd0,
        RES_NONE      = 3'd1,
        RES_COMPLETED = 3'd2,
        RES_BAD_ID    = 3'd3,
        RES_TICK      = 3'd4
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_EXP_RD, ST_EXP_CHK, ST_ACT, ST_MV_RD, ST_MV_UNP,
        ST_MV_UNN, ST_MV_APT, ST_MV_APL, ST_STAMP, ST_DUR, ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        KIND_EXP, KIND_REQ, KIND_CMP
    } kind_t;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic rd;
        logic rd_head;
        logic exp_take;
        logic req_take;
        logic cmp_take;
        logic unp;
        logic unn;
        logic apt;
        logic apl;
        logic stamp;
        logic dur;
        logic tick;
        logic set_res;
        res_t res;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       rebuild;
        logic       run_nil;
        logic       pend_nil;
        logic       expire;
        logic       id_ok;
        logic [1:0] action;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/tdisp_ctrl.sv
// ----------------------------------------------------------------------------
// tdisp_ctrl
// Sequencer: clearing sweep, expiry walk, action and list-move micro steps.
// ----------------------------------------------------------------------------
`default_nettype none
`include "task_dispatcher_with_timeout_requeue_assert.svh"
module tdisp_ctrl
    import tdisp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            kind_reg  <= KIND_EXP;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE) || sts.rebuild;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.res    = RES_BAD_ID;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXP_RD;
                end
            end
            ST_EXP_RD:
            begin
                if (sts.run_nil)
                    state_next = ST_ACT;
                else
                begin
                    cmd.rd      = 1'b1;
                    cmd.rd_head = 1'b1;
                    state_next  = ST_EXP_CHK;
                end
            end
            ST_EXP_CHK:
            begin
                if (sts.expire)
                begin
                    cmd.exp_take = 1'b1;
                    kind_next    = KIND_EXP;
                    state_next   = ST_MV_RD;
                end
                else
                    state_next = ST_ACT;
            end
            ST_ACT:
            begin
                case (sts.action)
                    ACT_REQUEST:
                    begin
                        if (sts.pend_nil)
                        begin
                            cmd.set_res = 1'b1;
                            cmd.res     = RES_NONE;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            cmd.req_take = 1'b1;
                            kind_next    = KIND_REQ;
                            state_next   = ST_MV_RD;
                        end
                    end
                    ACT_COMPLETE:
                    begin
                        if (sts.id_ok)
                        begin
                            cmd.cmp_take = 1'b1;
                            kind_next    = KIND_CMP;
                            state_next   = ST_MV_RD;
                        end
                        else
                        begin
                            cmd.set_res = 1'b1;
                            cmd.res     = RES_BAD_ID;
                            state_next  = ST_FINISH;
                        end
                    end
                    ACT_TICK:
                    begin
                        cmd.tick    = 1'b1;
                        cmd.set_res = 1'b1;
                        cmd.res     = RES_TICK;
                        state_next  = ST_FINISH;
                    end
                    default:
                    begin
                        cmd.set_res = 1'b1;
                        cmd.res     = RES_BAD_ID;
                        state_next  = ST_FINISH;
                    end
                endcase
            end
            ST_MV_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_MV_UNP;
            end
            ST_MV_UNP:
            begin
                cmd.unp    = 1'b1;
                state_next = ST_MV_UNN;
            end
            ST_MV_UNN:
            begin
                cmd.unn    = 1'b1;
                state_next = ST_MV_APT;
            end
            ST_MV_APT:
            begin
                cmd.apt    = 1'b1;
                state_next = ST_MV_APL;
            end
            ST_MV_APL:
            begin
                cmd.apl = 1'b1;
                case (kind_reg)
                    KIND_EXP: state_next = ST_EXP_RD;
                    KIND_REQ: state_next = ST_STAMP;
                    default:  state_next = ST_DUR;
                endcase
            end
            ST_STAMP:
            begin
                cmd.stamp   = 1'b1;
                cmd.set_res = 1'b1;
                cmd.res     = RES_GRANTED;
                state_next  = ST_FINISH;
            end
            ST_DUR:
            begin
                cmd.dur     = 1'b1;
                cmd.set_res = 1'b1;
                cmd.res     = RES_COMPLETED;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_CLEAR;
        endcase
        // a task_count write restarts the clearing sweep
        if (sts.rebuild)
            state_next = ST_CLEAR;
    end

    `TD_ASSERT_IMP(a_load_free, cmd.load_out, sts.out_free)
    `TD_ASSERT_NXT(a_rebuild_clear, sts.rebuild, state_reg == ST_CLEAR)
    `TD_ASSERT_IMP(a_take_onehot, 1'b1, $onehot0({cmd.exp_take, cmd.req_take, cmd.cmp_take}))

endmodule
`default_nettype wire

>>> hw/rtl/tdisp_dpath.sv
// ----------------------------------------------------------------------------
// tdisp_dpath
// Link memories, list heads/tails/sizes, time counter, config and result.
// ----------------------------------------------------------------------------
`default_nettype none
module tdisp_dpath
    import tdisp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic [1:0]        action,
    input  wire logic [ID_W-1:0]   task_id,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output logic [2:0]             status,
    output logic [ID_W-1:0]        task_id_out,
    output logic [31:0]            duration,
    output logic [LINK_W-1:0]      pending_count,
    output logic [LINK_W-1:0]      running_count,
    output logic [LINK_W-1:0]      done_count,
    output logic [LINK_W-1:0]      expired_count,
    input  wire cmd_t              cmd,
    output sts_t                   sts
);

    logic [LINK_W-1:0] count_reg;
    logic [31:0]       timeout_reg;
    logic [31:0]       tick_reg;
    logic [LINK_W-1:0] head_reg [3];
    logic [LINK_W-1:0] tail_reg [3];
    logic [LINK_W-1:0] size_reg [3];
    logic [ID_W-1:0]   clr_idx_reg;
    logic [1:0]        act_reg;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   t_reg;
    logic [1:0]        dst_reg;
    logic [LINK_W-1:0] exp_reg;
    res_t              res_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic [31:0]       res_dur_reg;

    logic [1:0]        tag_mem   [MAX_TASKS];
    logic [LINK_W-1:0] prev_mem  [MAX_TASKS];
    logic [LINK_W-1:0] next_mem  [MAX_TASKS];
    logic [31:0]       start_mem [MAX_TASKS];
    logic [1:0]        tag_rd;
    logic [LINK_W-1:0] prev_rd, next_rd;
    logic [31:0]       start_rd;

    logic              wr_count;
    logic [LINK_W-1:0] new_count;
    logic [1:0]        src;
    logic [ID_W-1:0]   rd_addr;
    logic [LINK_W-1:0] clr_i, clr_prev, clr_next;
    logic [31:0]       age;

    assign wr_count  = cfg_valid && (cfg_index == CFG_TASK_COUNT);
    always_comb
    begin
        new_count = cfg_data[LINK_W-1:0];
        if (new_count == '0)
            new_count = LINK_W'(1);
        else if (new_count > NIL_LINK)
            new_count = NIL_LINK;
    end

    assign src     = (tag_rd == 2'd3) ? LIST_PENDING : tag_rd;
    assign rd_addr = cmd.rd_head ? head_reg[LIST_RUNNING][ID_W-1:0] : t_reg;
    assign clr_i   = {1'b0, clr_idx_reg};
    assign clr_prev = (clr_idx_reg == '0 || clr_i >= count_reg) ? NIL_LINK : clr_i - 1'b1;
    assign clr_next = ({1'b0, clr_i} + 12'd1 < {1'b0, count_reg}) ? clr_i + 1'b1 : NIL_LINK;
    assign age      = tick_reg - start_rd;

    assign sts.clr_last = clr_idx_reg == ID_W'(MAX_TASKS - 1);
    assign sts.rebuild  = wr_count;
    assign sts.run_nil  = head_reg[LIST_RUNNING] == NIL_LINK;
    assign sts.pend_nil = head_reg[LIST_PENDING] == NIL_LINK;
    assign sts.expire   = age > timeout_reg;
    assign sts.id_ok    = {1'b0, id_reg} < count_reg;
    assign sts.action   = act_reg;
    assign sts.out_free = !out_valid || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= NIL_LINK;
            timeout_reg <= RESET_TIMEOUT;
            tick_reg    <= '0;
            clr_idx_reg <= '0;
            head_reg[LIST_PENDING] <= '0;
            tail_reg[LIST_PENDING] <= NIL_LINK - 1'b1;
            size_reg[LIST_PENDING] <= NIL_LINK;
            for (int k = 1; k < 3; k++)
            begin
                head_reg[k] <= NIL_LINK;
                tail_reg[k] <= NIL_LINK;
                size_reg[k] <= '0;
            end
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_TASK_TIMEOUT)
                timeout_reg <= cfg_data;
            if (wr_count)
            begin
                count_reg   <= new_count;
                clr_idx_reg <= '0;
                head_reg[LIST_PENDING] <= '0;
                tail_reg[LIST_PENDING] <= new_count - 1'b1;
                size_reg[LIST_PENDING] <= new_count;
                for (int k = 1; k < 3; k++)
                begin
                    head_reg[k] <= NIL_LINK;
                    tail_reg[k] <= NIL_LINK;
                    size_reg[k] <= '0;
                end
            end
            else
            begin
                if (cmd.clr_step)
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                // unlink from source list
                if (cmd.unp && prev_rd == NIL_LINK)
                    head_reg[src] <= next_rd;
                if (cmd.unn)
                begin
                    if (next_rd == NIL_LINK)
                        tail_reg[src] <= prev_rd;
                    if (size_reg[src] != '0)
                        size_reg[src] <= size_reg[src] - 1'b1;
                end
                // append at destination tail
                if (cmd.apl)
                begin
                    if (tail_reg[dst_reg] == NIL_LINK)
                        head_reg[dst_reg] <= {1'b0, t_reg};
                    tail_reg[dst_reg] <= {1'b0, t_reg};
                    size_reg[dst_reg] <= size_reg[dst_reg] + 1'b1;
                end
            end
            if (cmd.tick)
                tick_reg <= tick_reg + 1'b1;
            if (cmd.load_out)
                out_valid <= 1'b1;
            else if (!out_stall)
                out_valid <= 1'b0;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg     <= action;
            id_reg      <= task_id;
            exp_reg     <= '0;
            res_id_reg  <= '0;
            res_dur_reg <= '0;
        end
        if (cmd.exp_take)
        begin
            t_reg   <= head_reg[LIST_RUNNING][ID_W-1:0];
            dst_reg <= LIST_PENDING;
            exp_reg <= exp_reg + 1'b1;
        end
        if (cmd.req_take)
        begin
            t_reg   <= head_reg[LIST_PENDING][ID_W-1:0];
            dst_reg <= LIST_RUNNING;
        end
        if (cmd.cmp_take)
        begin
            t_reg   <= id_reg;
            dst_reg <= LIST_DONE;
        end
        if (cmd.set_res)
            res_reg <= cmd.res;
        if (cmd.stamp)
            res_id_reg <= t_reg;
        if (cmd.dur)
        begin
            res_id_reg  <= t_reg;
            res_dur_reg <= age;
        end
        if (cmd.load_out)
        begin
            status        <= res_reg;
            task_id_out   <= res_id_reg;
            duration      <= res_dur_reg;
            pending_count <= size_reg[LIST_PENDING];
            running_count <= size_reg[LIST_RUNNING];
            done_count    <= size_reg[LIST_DONE];
            expired_count <= exp_reg;
        end
    end

    // link memories
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            tag_rd   <= tag_mem[rd_addr];
            prev_rd  <= prev_mem[rd_addr];
            next_rd  <= next_mem[rd_addr];
            start_rd <= start_mem[rd_addr];
        end
        if (cmd.clr_step)
            tag_mem[clr_idx_reg] <= LIST_PENDING;
        else if (cmd.apt)
            tag_mem[t_reg] <= dst_reg;
        if (cmd.clr_step)
            prev_mem[clr_idx_reg] <= clr_prev;
        else if (cmd.unn && next_rd != NIL_LINK)
            prev_mem[next_rd[ID_W-1:0]] <= prev_rd;
        else if (cmd.apt)
            prev_mem[t_reg] <= tail_reg[dst_reg];
        if (cmd.clr_step)
            next_mem[clr_idx_reg] <= clr_next;
        else if (cmd.unp && prev_rd != NIL_LINK)
            next_mem[prev_rd[ID_W-1:0]] <= next_rd;
        else if (cmd.apt)
            next_mem[t_reg] <= NIL_LINK;
        else if (cmd.apl && tail_reg[dst_reg] != NIL_LINK)
            next_mem[tail_reg[dst_reg][ID_W-1:0]] <= {1'b0, t_reg};
        if (cmd.clr_step)
            start_mem[clr_idx_reg] <= '0;
        else if (cmd.stamp)
            start_mem[t_reg] <= tick_reg;
    end

endmodule
`default_nettype wire

>>> hw/rtl/task_dispatcher_with_timeout_requeue.sv
// ----------------------------------------------------------------------------
// task_dispatcher_with_timeout_requeue
// Lease-based task dispatcher with pending, running and done lists.
// ----------------------------------------------------------------------------
// After reset and after every task_count write the block sweeps its link
// memories entry by entry with in_stall high. For each accepted item it then
// requeues timed-out tasks from the running head to the pending tail until
// the head has not timed out, and then acts: a tick or a rejected request
// finishes at once, a grant or a completion first moves the task between
// lists in the micro steps read, unlink, unlink, append and append, then
// stamps the start time or records the duration. The result is presented in
// the same cycle in which the next input transfer can first happen.
// The next item is taken while the previous result waits on out_stall.
`default_nettype none
module task_dispatcher_with_timeout_requeue
    import tdisp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        action,
    input  wire logic [ID_W-1:0]   task_id,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [2:0]             status,
    output logic [ID_W-1:0]        task_id_out,
    output logic [31:0]            duration,
    output logic [LINK_W-1:0]      pending_count,
    output logic [LINK_W-1:0]      running_count,
    output logic [LINK_W-1:0]      done_count,
    output logic [LINK_W-1:0]      expired_count
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tdisp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tdisp_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .task_id       (task_id),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .task_id_out   (task_id_out),
        .duration      (duration),
        .pending_count (pending_count),
        .running_count (running_count),
        .done_count    (done_count),
        .expired_count (expired_count),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule
`default_nettype wire
